// File: hw/rtl/swcd_pkg.sv
// Shared types, codes and constants for the stopwatch / countdown timer menu core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package swcd_pkg;

  // Stream and register port widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // Item kinds (tuser)
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  // Pages
  localparam logic [1:0] PAGE_MENU      = 2'd0;
  localparam logic [1:0] PAGE_STOPWATCH = 2'd1;
  localparam logic [1:0] PAGE_COUNTDOWN = 2'd2;

  // Run modes
  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;

  // Adjustable fields
  localparam logic [1:0] FIELD_SEC  = 2'd0;
  localparam logic [1:0] FIELD_MIN  = 2'd1;
  localparam logic [1:0] FIELD_HOUR = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_TPS    = 2'd0;
  localparam logic [1:0] REG_TPA    = 2'd1;
  localparam logic [1:0] REG_JOY_LO = 2'd2;
  localparam logic [1:0] REG_JOY_HI = 2'd3;

  // Register reset values
  localparam logic [7:0] TPS_RESET    = 8'd30;
  localparam logic [7:0] TPA_RESET    = 8'd6;
  localparam logic [9:0] JOY_LO_RESET = 10'd200;
  localparam logic [9:0] JOY_HI_RESET = 10'd900;

  // Time limits
  localparam logic [5:0] MS_MAX   = 6'd59;
  localparam logic [6:0] MS_WRAP  = 7'd60;
  localparam logic [6:0] HOUR_MAX = 7'd99;

  typedef struct packed {
    logic [7:0] tps;
    logic [7:0] tpa;
    logic [9:0] joy_lo;
    logic [9:0] joy_hi;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic       encoder_level;
    logic       enter_press;
    logic       start_press;
    logic [9:0] joy_x;
    logic [9:0] joy_y;
  } item_t;

  typedef struct packed {
    logic [1:0] page;
    logic       cursor;
    logic       last_encoder;
    logic [1:0] mode;
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [1:0] field;
    logic       alarm;
    logic [7:0] sec_pre;
    logic [7:0] adj_pre;
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/stopwatch_countdown_timer_menu_core.sv
// Stopwatch / countdown timer menu core: one result word per input word.
// The word passes through the input register, then the result register, before m_tvalid
// rises; the result register holds the word while m_tready is low.
// Throughput: one word per cycle while m_tready drains the result; the state update loop sets it.
// Reset (rst, synchronous): registers to defaults, time/menu state cleared, pipe empty.
// Depends on swcd_pkg, swcd_cfg, swcd_update.
`timescale 1ns / 1ps
`default_nettype none

module stopwatch_countdown_timer_menu_core
  import swcd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // [0] encoder_level, [1] enter_press, [2] start_press,
  // [12:3] joy_x, [22:13] joy_y, [23] zero
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // [0] command: 0 tick, 1 button scan
  input  wire logic                   s_tuser,
  // result stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [1:0] page, [2] cursor_row, [4:3] run_mode, [11:5] hours,
  // [17:12] minutes, [23:18] seconds, [25:24] field_select, [26] alarm, [31:27] zero
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [PDATA_W-1:0]     pwdata,
  output logic      [PDATA_W-1:0]     prdata,
  output logic                        pready
);

  cfg_t   cfg;
  item_t  in_item;
  logic   in_valid;
  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   fire;

  swcd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swcd_update u_update (
    .cfg  (cfg),
    .item (in_item),
    .cur  (state),
    .nxt  (state_next)
  );

  // Update fires when the input register holds a word and the result
  // register is empty or being drained this cycle.
  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;
  assign m_tvalid = out_valid;

  // input register: control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // input register: payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command       <= s_tuser;
      in_item.encoder_level <= s_tdata[0];
      in_item.enter_press   <= s_tdata[1];
      in_item.start_press   <= s_tdata[2];
      in_item.joy_x         <= s_tdata[12:3];
      in_item.joy_y         <= s_tdata[22:13];
    end
  end

  // timer/menu state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.page         <= PAGE_MENU;
      state.cursor       <= 1'b0;
      state.last_encoder <= 1'b1;
      state.mode         <= MODE_STOP;
      state.hours        <= 7'd0;
      state.minutes      <= 6'd0;
      state.seconds      <= 6'd0;
      state.field        <= FIELD_SEC;
      state.alarm        <= 1'b0;
      state.sec_pre      <= 8'd0;
      state.adj_pre      <= 8'd0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result register: shows the state after the word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {5'd0, state_next.alarm, state_next.field, state_next.seconds,
                  state_next.minutes, state_next.hours, state_next.mode,
                  state_next.cursor, state_next.page};
    end
  end

  // Counting modes belong to their own page.
  a_mode_page: assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_UP) |-> (state.page == PAGE_STOPWATCH))
    else $error("stopwatch running off its page");

  a_mode_down_page: assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_DOWN) |-> (state.page == PAGE_COUNTDOWN))
    else $error("countdown running off its page");

  // Alarm only while the countdown is stopped.
  a_alarm_stopped: assert property (@(posedge clk) disable iff (rst)
    state.alarm |-> (state.mode == MODE_STOP))
    else $error("alarm raised while counting");

  // A field other than seconds can only be picked on the countdown page.
  a_field_page: assert property (@(posedge clk) disable iff (rst)
    (state.field != FIELD_SEC) |-> (state.page == PAGE_COUNTDOWN))
    else $error("field selected off the countdown page");

  // Minutes and seconds stay in range.
  a_ms_range: assert property (@(posedge clk) disable iff (rst)
    (state.seconds <= MS_MAX) && (state.minutes <= MS_MAX))
    else $error("minutes or seconds out of range");

endmodule

`default_nettype wire

// File: hw/rtl/swcd_cfg.sv
// APB register file: tick periods and joystick thresholds.
// Depends on swcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swcd_cfg
  import swcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t        regs;
  logic        wr_en;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.tps    <= TPS_RESET;
      regs.tpa    <= TPA_RESET;
      regs.joy_lo <= JOY_LO_RESET;
      regs.joy_hi <= JOY_HI_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_TPS:    regs.tps    <= pwdata[7:0];
        REG_TPA:    regs.tpa    <= pwdata[7:0];
        REG_JOY_LO: regs.joy_lo <= pwdata[9:0];
        REG_JOY_HI: regs.joy_hi <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TPS:    prdata = {24'd0, regs.tps};
      REG_TPA:    prdata = {24'd0, regs.tpa};
      REG_JOY_LO: prdata = {22'd0, regs.joy_lo};
      REG_JOY_HI: prdata = {22'd0, regs.joy_hi};
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/swcd_update.sv
// Next-state logic for one tick or button scan of the timer menu.
// Depends on swcd_pkg. Purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module swcd_update
  import swcd_pkg::*;
(
  input  cfg_t   cfg,
  input  item_t  item,
  input  state_t cur,
  output state_t nxt
);

  logic [7:0] sec_pre_inc;
  logic [7:0] adj_pre_inc;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic       at_limit;
  logic       time_nz;

  assign sec_pre_inc = cur.sec_pre + 8'd1;
  assign adj_pre_inc = cur.adj_pre + 8'd1;
  assign sec_inc     = {1'b0, cur.seconds} + 7'd1;
  assign min_inc     = {1'b0, cur.minutes} + 7'd1;
  assign at_limit    = (cur.hours >= HOUR_MAX) && (cur.minutes >= MS_MAX) &&
                       (cur.seconds >= MS_MAX);
  assign time_nz     = (cur.seconds != 6'd0) || (cur.minutes != 6'd0) ||
                       (cur.hours != 7'd0);

  always_comb begin
    nxt = cur;
    if (item.command == CMD_SCAN) begin
      // encoder edge moves the cursor only on the menu
      if ((item.encoder_level != cur.last_encoder) && (cur.page == PAGE_MENU))
        nxt.cursor = ~cur.cursor;
      nxt.last_encoder = item.encoder_level;

      if (item.enter_press && (cur.page == PAGE_MENU)) begin
        nxt.page = nxt.cursor ? PAGE_COUNTDOWN : PAGE_STOPWATCH;
      end else if (item.enter_press) begin
        nxt.page    = PAGE_MENU;
        nxt.mode    = MODE_STOP;
        nxt.cursor  = 1'b0;
        nxt.field   = FIELD_SEC;
        nxt.alarm   = 1'b0;
        nxt.hours   = 7'd0;
        nxt.minutes = 6'd0;
        nxt.seconds = 6'd0;
      end else if (item.start_press && (cur.page == PAGE_STOPWATCH)) begin
        nxt.mode = (cur.mode == MODE_STOP) ? MODE_UP : MODE_STOP;
      end else if (item.start_press && (cur.page == PAGE_COUNTDOWN)) begin
        if (cur.mode == MODE_STOP) begin
          nxt.mode  = MODE_DOWN;
          nxt.alarm = 1'b0;
        end else begin
          nxt.mode = MODE_STOP;
        end
      end
    end else begin
      // one-second prescaler
      if (sec_pre_inc >= cfg.tps) begin
        nxt.sec_pre = 8'd0;
        if (cur.mode == MODE_UP) begin
          if (!at_limit) begin
            if (sec_inc >= MS_WRAP) begin
              nxt.seconds = 6'd0;
              if (min_inc >= MS_WRAP) begin
                nxt.minutes = 6'd0;
                if (cur.hours < HOUR_MAX)
                  nxt.hours = cur.hours + 7'd1;
              end else begin
                nxt.minutes = min_inc[5:0];
              end
            end else begin
              nxt.seconds = sec_inc[5:0];
            end
          end
        end else if (cur.mode == MODE_DOWN) begin
          if (time_nz) begin
            if (cur.seconds != 6'd0) begin
              nxt.seconds = cur.seconds - 6'd1;
            end else begin
              nxt.seconds = MS_MAX;
              if (cur.minutes != 6'd0) begin
                nxt.minutes = cur.minutes - 6'd1;
              end else begin
                nxt.minutes = MS_MAX;
                nxt.hours   = cur.hours - 7'd1;
              end
            end
          end else begin
            nxt.mode  = MODE_STOP;
            nxt.alarm = 1'b1;
          end
        end
      end else begin
        nxt.sec_pre = sec_pre_inc;
      end

      // joystick adjust prescaler; sees the mode after second counting
      if (adj_pre_inc >= cfg.tpa) begin
        nxt.adj_pre = 8'd0;
        if ((cur.page == PAGE_COUNTDOWN) && (nxt.mode == MODE_STOP)) begin
          if (item.joy_y < cfg.joy_lo) begin
            case (cur.field)
              FIELD_SEC:  nxt.field = FIELD_MIN;
              FIELD_MIN:  nxt.field = FIELD_HOUR;
              FIELD_HOUR: nxt.field = FIELD_SEC;
              default: ;
            endcase
          end else if (item.joy_y > cfg.joy_hi) begin
            case (cur.field)
              FIELD_SEC:  nxt.field = FIELD_HOUR;
              FIELD_MIN:  nxt.field = FIELD_SEC;
              FIELD_HOUR: nxt.field = FIELD_MIN;
              default: ;
            endcase
          end else if (item.joy_x > cfg.joy_hi) begin
            case (cur.field)
              FIELD_SEC:  if (cur.seconds < MS_MAX) nxt.seconds = cur.seconds + 6'd1;
              FIELD_MIN:  if (cur.minutes < MS_MAX) nxt.minutes = cur.minutes + 6'd1;
              FIELD_HOUR: if (cur.hours < {1'b0, MS_MAX}) nxt.hours = cur.hours + 7'd1;
              default: ;
            endcase
          end else if (item.joy_x < cfg.joy_lo) begin
            case (cur.field)
              FIELD_SEC:  if (cur.seconds != 6'd0) nxt.seconds = cur.seconds - 6'd1;
              FIELD_MIN:  if (cur.minutes != 6'd0) nxt.minutes = cur.minutes - 6'd1;
              FIELD_HOUR: if (cur.hours != 7'd0) nxt.hours = cur.hours - 7'd1;
              default: ;
            endcase
          end
        end
      end else begin
        nxt.adj_pre = adj_pre_inc;
      end
    end
  end

endmodule

`default_nettype wire
